// ===== design/urff_pkg.sv =====
package urff_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_FIELD_DEF  = 64;

   localparam int MAX_DIGITS  = 32;
   localparam int DIGIT_W     = 4;
   localparam int NDIG_W      = 6;
   localparam int PREC_W      = 6;
   localparam int FIELD_W     = 7;
   localparam int RADIX_W     = 5;
   localparam int KIND_W      = 3;
   localparam int CHAR_W      = 8;
   localparam int STEP_BITS   = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

   localparam logic [KIND_W-1:0] KIND_DEC    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OCT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HEXL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HEXU   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PTR    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_BINL   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_BINU   = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LX    = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_UX    = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LB    = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_UB    = 8'h42;
   // bases such that base + digit lands on 'a' or 'A' for digit ten
   localparam logic [CHAR_W-1:0] CHAR_LHEX_BASE = 8'h57;
   localparam logic [CHAR_W-1:0] CHAR_UHEX_BASE = 8'h37;

   // one field, digits most significant first at index 0
   typedef struct packed {
      logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
      logic [NDIG_W-1:0]                  nd;
      logic [PREC_W-1:0]                  prec;
      logic [FIELD_W-1:0]                 minw;
      logic [1:0]                         sign;
      logic [CHAR_W-1:0]                  pfx1;
      logic                               upper;
      logic                               zero_pad;
      logic                               left;
   } desc_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] dx;
      dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + dx;
      end else if (upper) begin
         return CHAR_UHEX_BASE + dx;
      end else begin
         return CHAR_LHEX_BASE + dx;
      end
   endfunction

endpackage

// ===== design/urff_front.sv =====
module urff_front import urff_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [RADIX_W-1:0]    req_radix,
   input  logic [KIND_W-1:0]     req_conv_kind,
   input  logic                  req_hash_flag,
   input  logic                  req_zero_flag,
   input  logic                  req_left_flag,
   input  logic [PREC_W-1:0]     req_precision,
   input  logic [FIELD_W-1:0]    req_field_min,
   output logic                  push,
   output desc_type              push_desc,
   input  logic                  queue_full
);

   localparam int CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_W   = CHUNKS * STEP_BITS;
   localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_DIVIDE = 3'b010,
      F_PUSH   = 3'b100
   } front_state_type;

   front_state_type     state_ff, state_in;
   desc_type            desc_ff, desc_in;
   logic [DIV_W-1:0]    t_ff, t_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic [RADIX_W-1:0]  radix_ff, radix_in;

   logic [KIND_W-1:0]   kind_c;
   logic                value_nz;
   logic [PREC_W-1:0]   prec_c;
   logic [FIELD_W-1:0]  minw_c;
   logic [RADIX_W-1:0]  radix_c;
   logic [1:0]          sign_c;
   logic [CHAR_W-1:0]   pfx1_c;

   logic [STEP_BITS-1:0] qbits;
   logic [DIGIT_W-1:0]   step_rem;
   logic [DIV_W-1:0]     step_t;

   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH) && !queue_full;
   assign push_desc = desc_ff;

   // clamp and classify the incoming request
   always_comb begin
      kind_c   = (req_conv_kind == KIND_UNUSED) ? KIND_DEC : req_conv_kind;
      value_nz = |req_value;
      prec_c   = ({1'b0, req_precision} > FIELD_W'(MAX_FIELD - 2)) ?
                 PREC_W'(MAX_FIELD - 2) : req_precision;
      minw_c   = (req_field_min > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : req_field_min;
      if (req_radix < RADIX_MIN) begin
         radix_c = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_c = RADIX_MAX;
      end else begin
         radix_c = req_radix;
      end
      sign_c = 2'd0;
      pfx1_c = CHAR_LX;
      if (req_hash_flag) begin
         if (kind_c == KIND_OCT) begin
            // octal keeps its 0 unless a zero value is covered by precision zeros
            if (value_nz || (prec_c == '0)) begin
               sign_c = 2'd1;
            end
         end else if ((kind_c == KIND_PTR) || (value_nz && (kind_c != KIND_DEC))) begin
            sign_c = 2'd2;
            case (kind_c)
               KIND_HEXU: pfx1_c = CHAR_UX;
               KIND_BINL: pfx1_c = CHAR_LB;
               KIND_BINU: pfx1_c = CHAR_UB;
               default:   pfx1_c = CHAR_LX;
            endcase
         end
      end
   end

   // restoring division by the radix, STEP_BITS quotient bits per cycle
   always_comb begin
      logic [DIGIT_W-1:0] r;
      logic [DIGIT_W:0]   r5;
      r     = rem_ff;
      qbits = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         r5 = {r, t_ff[DIV_W-1-i]};
         if (r5 >= radix_ff) begin
            qbits[STEP_BITS-1-i] = 1'b1;
            r5 = r5 - radix_ff;
         end
         r = r5[DIGIT_W-1:0];
      end
      step_rem = r;
      step_t   = DIV_W'({t_ff, qbits});
   end

   always_comb begin
      state_in = state_ff;
      desc_in  = desc_ff;
      t_in     = t_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      radix_in = radix_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               desc_in.digits   = '0;
               desc_in.nd       = '0;
               desc_in.prec     = prec_c;
               desc_in.minw     = minw_c;
               desc_in.sign     = sign_c;
               desc_in.pfx1     = pfx1_c;
               desc_in.upper    = (kind_c == KIND_HEXU);
               desc_in.zero_pad = req_zero_flag;
               desc_in.left     = req_left_flag;
               t_in     = DIV_W'(req_value);
               rem_in   = '0;
               chunk_in = '0;
               radix_in = radix_c;
               // zero value with zero precision has no digits at all
               state_in = (value_nz || (prec_c != '0)) ? F_DIVIDE : F_PUSH;
            end
         end
         F_DIVIDE: begin
            t_in     = step_t;
            rem_in   = step_rem;
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CHUNK_W'(CHUNKS - 1)) begin
               desc_in.digits = {desc_ff.digits[MAX_DIGITS-2:0], step_rem};
               desc_in.nd     = desc_ff.nd + 1'b1;
               rem_in         = '0;
               chunk_in       = '0;
               if (step_t == '0) begin
                  state_in = F_PUSH;
               end
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff  <= desc_in;
      t_ff     <= t_in;
      rem_ff   <= rem_in;
      chunk_ff <= chunk_in;
      radix_ff <= radix_in;
   end

endmodule

// ===== design/urff_queue.sv =====
module urff_queue import urff_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output desc_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== design/urff_back.sv =====
module urff_back import urff_pkg::*; #(
   parameter int MAX_FIELD = MAX_FIELD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   output logic              pop,
   input  desc_type          head,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_last
);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_SIZE = 4'b0010,
      B_PREP = 4'b0100,
      B_EMIT = 4'b1000
   } back_state_type;

   back_state_type     state_ff, state_in;
   desc_type           cur_ff, cur_in;
   logic [FIELD_W-1:0] size_ff, size_in;
   logic [FIELD_W-1:0] width_ff, width_in;
   logic [FIELD_W-1:0] pad_ff, pad_in;
   logic [FIELD_W-1:0] b1_ff, b1_in;
   logic [FIELD_W-1:0] b2_ff, b2_in;
   logic [FIELD_W-1:0] b4_ff, b4_in;
   logic [FIELD_W-1:0] b5_ff, b5_in;
   logic [FIELD_W-1:0] pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic [FIELD_W-1:0] nd_x, sign_x, wsum, wmax;
   logic [CHAR_W-1:0]  cur_char;
   logic               in_digits;
   logic               at_last;

   assign pop          = (state_ff == B_IDLE) && !queue_empty;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   assign nd_x   = FIELD_W'(cur_ff.nd);
   assign sign_x = FIELD_W'(cur_ff.sign);

   // field layout: spaces | prefix | zero pad | precision zeros | digits | spaces
   always_comb begin
      wsum = size_ff + sign_x;
      wmax = (wsum > cur_ff.minw) ? wsum : cur_ff.minw;
   end

   always_comb begin
      in_digits = 1'b0;
      if (pos_ff < b1_ff) begin
         cur_char = CHAR_SPACE;
      end else if (pos_ff < b2_ff) begin
         cur_char = (pos_ff == b1_ff) ? CHAR_ZERO : cur_ff.pfx1;
      end else if (pos_ff < b4_ff) begin
         cur_char = CHAR_ZERO;
      end else if (pos_ff < b5_ff) begin
         cur_char  = digit_char(cur_ff.digits[0], cur_ff.upper);
         in_digits = 1'b1;
      end else begin
         cur_char = CHAR_SPACE;
      end
      at_last = (pos_ff == width_ff - 1'b1);
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      size_in      = size_ff;
      width_in     = width_ff;
      pad_in       = pad_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b4_in        = b4_ff;
      b5_in        = b5_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               cur_in   = head;
               size_in  = (head.prec > head.nd) ? FIELD_W'(head.prec) : FIELD_W'(head.nd);
               state_in = B_SIZE;
            end
         end
         B_SIZE: begin
            width_in = (wmax > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : wmax;
            pad_in   = width_in - wsum;
            state_in = B_PREP;
         end
         B_PREP: begin
            b1_in    = (!cur_ff.left && !cur_ff.zero_pad) ? pad_ff : '0;
            b2_in    = b1_in + sign_x;
            b4_in    = ((!cur_ff.left && cur_ff.zero_pad) ? b2_in + pad_ff : b2_in)
                       + (size_ff - nd_x);
            b5_in    = b4_in + nd_x;
            pos_in   = '0;
            // an empty field produces no beats
            state_in = (width_ff == '0) ? B_IDLE : B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = cur_char;
               rsp_last_in  = at_last;
               pos_in       = pos_ff + 1'b1;
               if (in_digits) begin
                  cur_in.digits = {{DIGIT_W{1'b0}}, cur_ff.digits[MAX_DIGITS-1:1]};
               end
               if (at_last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      size_ff     <= size_in;
      width_ff    <= width_in;
      pad_ff      <= pad_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b4_ff       <= b4_in;
      b5_ff       <= b5_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== design/unsigned_radix_field_formatter.sv =====
// Formats an unsigned value as a printf-style integer field and returns it one ASCII
// character per beat, leftmost first, with rsp_last on the final character; a zero value
// with zero precision, no prefix and zero width gives no beats. The front takes a request,
// then extracts digits with a restoring divider that retires 8 quotient bits per cycle;
// each digit is a full division of the remaining value in 8-bit chunks, and the front
// stays busy until the last digit is out and the descriptor is pushed into the queue.
// The back loads the descriptor, sizes the field and places its section boundaries, then
// emits one character per cycle while rsp_stall does not hold the output. A two-entry
// queue between them lets the front work on the next request while the back is still
// emitting, so the sustained rate is set by the slower of the divider loop and the output.
module unsigned_radix_field_formatter import urff_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_value,
   input  logic [RADIX_W-1:0] req_radix,
   input  logic [KIND_W-1:0]  req_conv_kind,
   input  logic               req_hash_flag,
   input  logic               req_zero_flag,
   input  logic               req_left_flag,
   input  logic [PREC_W-1:0]  req_precision,
   input  logic [FIELD_W-1:0] req_field_min,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_last
);

   logic     push;
   desc_type push_desc;
   logic     queue_full;
   logic     pop;
   logic     queue_empty;
   desc_type head;

   urff_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_FIELD  (MAX_FIELD)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value[VALUE_BITS-1:0]),
      .req_radix     (req_radix),
      .req_conv_kind (req_conv_kind),
      .req_hash_flag (req_hash_flag),
      .req_zero_flag (req_zero_flag),
      .req_left_flag (req_left_flag),
      .req_precision (req_precision),
      .req_field_min (req_field_min),
      .push          (push),
      .push_desc     (push_desc),
      .queue_full    (queue_full)
   );

   urff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   urff_back #(
      .MAX_FIELD (MAX_FIELD)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .pop          (pop),
      .head         (head),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   // a nonzero precision always leaves at least one extracted digit
   a_digits_with_precision: assert property (@(posedge clock) disable iff (reset)
      (push && (push_desc.prec != '0)) |-> (push_desc.nd != '0))
      else $error("descriptor with precision but no digits");

   // never more digits than value bits (radix two worst case)
   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_desc.nd <= NDIG_W'(VALUE_BITS)))
      else $error("digit count exceeds value width");

   // the front is busy in the cycle after it takes a beat
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("front accepted a beat without going busy");

endmodule
